@@ design/gtbp_pkg.sv @@
// ----------------------------------------------------------------------------
// gtbp_pkg
// Shared types, constants and helpers of the gshare/tournament predictor.
// ----------------------------------------------------------------------------
package gtbp_pkg;

    // default table geometry
    localparam int MAX_GLOBAL_BITS_DEF   = 13;
    localparam int MAX_LOCAL_BITS_DEF    = 11;
    localparam int MAX_PC_INDEX_BITS_DEF = 11;

    // stream payload
    localparam int PC_W       = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // configuration port
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_FIELD_W = 4;
    localparam int MODE_W      = 2;
    localparam int MASK_W      = 16;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_GHB  = 2'd1;
    localparam logic [1:0] REG_LHB  = 2'd2;
    localparam logic [1:0] REG_PIB  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GSHARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOURN  = 2'd2;

    localparam logic [MODE_W-1:0]      MODE_RST = MODE_GSHARE;
    localparam logic [CFG_FIELD_W-1:0] GHB_RST  = 4'd13;
    localparam logic [CFG_FIELD_W-1:0] LHB_RST  = 4'd10;
    localparam logic [CFG_FIELD_W-1:0] PIB_RST  = 4'd10;

    // two-bit saturating counters
    localparam int         CTR_W          = 2;
    localparam logic [1:0] CTR_MIN        = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] gmask;
        logic [MASK_W-1:0] lmask;
        logic [MASK_W-1:0] pmask;
    } cfg_t;

    // low-bit mask for a bit count, clamped to 1..max_bits
    function automatic logic [MASK_W-1:0] eff_mask(input logic [CFG_FIELD_W-1:0] v,
                                                   input int max_bits);
        logic [4:0]      n;
        logic [MASK_W:0] m;
        if (v == '0)
            n = 5'd1;
        else if (int'(v) > max_bits)
            n = 5'(max_bits);
        else
            n = 5'(v);
        m = ((MASK_W + 1)'(1) << n) - (MASK_W + 1)'(1);
        return m[MASK_W-1:0];
    endfunction

    function automatic logic [CTR_W-1:0] bump(input logic [CTR_W-1:0] c, input logic up);
        if (up)
            return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        else
            return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    endfunction

endpackage

@@ design/gshare_tournament_branch_predictor.sv @@
// Pipeline: accepted items pass stage 1, stage 2 and the output register.
// Throughput: one item per cycle while the output does not stall; one write port
// per table, with last-stage writes forwarded to the two younger items reading.
// Reset: history and pipeline clear at once; the tables are then swept one entry
// a cycle over 2^max(MAX_GLOBAL_BITS, MAX_LOCAL_BITS, MAX_PC_INDEX_BITS) addresses
// (8192 by default) with s_tready low; APB writes are taken throughout.
// ----------------------------------------------------------------------------
// gshare_tournament_branch_predictor
// Static / gshare / tournament branch direction predictor with predict and
// train beats on one stream.
// ----------------------------------------------------------------------------
module gshare_tournament_branch_predictor #(
    parameter int MAX_GLOBAL_BITS   = gtbp_pkg::MAX_GLOBAL_BITS_DEF,
    parameter int MAX_LOCAL_BITS    = gtbp_pkg::MAX_LOCAL_BITS_DEF,
    parameter int MAX_PC_INDEX_BITS = gtbp_pkg::MAX_PC_INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gtbp_pkg::S_TDATA_W-1:0]  s_tdata,   // pc [31:0], outcome [32]
    input  logic                            s_tuser,   // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gtbp_pkg::M_TDATA_W-1:0]  m_tdata,   // predicted_taken [0]
    output logic                            m_tuser,   // was_train
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtbp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gtbp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gtbp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int GW    = MAX_GLOBAL_BITS;
    localparam int LW    = MAX_LOCAL_BITS;
    localparam int PW    = MAX_PC_INDEX_BITS;
    localparam int CLR_W = (GW >= LW && GW >= PW) ? GW : ((LW >= PW) ? LW : PW);
    localparam int CW    = gtbp_pkg::CTR_W;
    localparam int GCC_W = 2 * CW;

    localparam logic [GCC_W-1:0] GCC_RST = {gtbp_pkg::CTR_WEAK_TAKEN, gtbp_pkg::CTR_WEAK_TAKEN};

    gtbp_pkg::cfg_t cfg;

    logic [GW-1:0] gmask;
    logic [LW-1:0] lmask;
    logic [PW-1:0] pmask;
    logic          is_gshare;
    logic          is_tourn;

    // handshake and input fields
    logic                     advance;
    logic                     accept;
    logic [gtbp_pkg::PC_W-1:0] in_pc;
    logic                     in_outcome;
    logic                     in_kind;

    // reset sweep
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // global history
    logic [GW-1:0] gh_reg, gh_next;
    logic [GW-1:0] gh_cur;
    logic [GW-1:0] in_gsidx;
    logic [PW-1:0] in_pidx;

    // stage 1: table reads land
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic          s1_outcome_reg;
    logic [GW-1:0] s1_gh_reg;
    logic [GW-1:0] s1_gsidx_reg;
    logic [PW-1:0] s1_pidx_reg;
    logic [LW-1:0] lh_res;
    logic [LW-1:0] s1_lidx;
    logic          gsh_res;
    logic [GCC_W-1:0] gcc_res;

    // stage 2: decide, update tables
    logic          s2_valid_reg;
    logic          s2_kind_reg;
    logic          s2_outcome_reg;
    logic [GW-1:0] s2_gh_reg;
    logic [GW-1:0] s2_gsidx_reg;
    logic [PW-1:0] s2_pidx_reg;
    logic [LW-1:0] s2_lidx_reg;
    logic          s2_gsh_reg;
    logic [CW-1:0] s2_ch_reg;
    logic [CW-1:0] s2_gc_reg;
    logic [CW-1:0] lc_cur;
    logic          use_global;
    logic          guess_right;
    logic [CW-1:0] ch_new;
    logic [CW-1:0] gc_new;
    logic [CW-1:0] lc_new;
    logic          pred_w;
    logic          w_train;

    // stage-2 table writes
    logic             gsh_we_w;
    logic             gcc_we_w;
    logic             lh_we_w;
    logic             lc_we_w;
    logic [GCC_W-1:0] gcc_wdata_w;
    logic [LW-1:0]    lh_wdata_w;

    // writes done at the previous advance
    logic             lw_gsh_valid_reg;
    logic [GW-1:0]    lw_gsh_addr_reg;
    logic             lw_gsh_data_reg;
    logic             lw_gcc_valid_reg;
    logic [GW-1:0]    lw_gcc_addr_reg;
    logic [GCC_W-1:0] lw_gcc_data_reg;
    logic             lw_lh_valid_reg;
    logic [PW-1:0]    lw_lh_addr_reg;
    logic [LW-1:0]    lw_lh_data_reg;
    logic             lw_lc_valid_reg;
    logic [LW-1:0]    lw_lc_addr_reg;
    logic [CW-1:0]    lw_lc_data_reg;

    // RAM ports
    logic             gsh_ram_we;
    logic [GW-1:0]    gsh_ram_waddr;
    logic             gsh_ram_wdata;
    logic             gsh_rdata;
    logic             gcc_ram_we;
    logic [GW-1:0]    gcc_ram_waddr;
    logic [GCC_W-1:0] gcc_ram_wdata;
    logic [GCC_W-1:0] gcc_rdata;
    logic             lh_ram_we;
    logic [PW-1:0]    lh_ram_waddr;
    logic [LW-1:0]    lh_ram_wdata;
    logic [LW-1:0]    lh_rdata;
    logic             lc_ram_we;
    logic [LW-1:0]    lc_ram_waddr;
    logic [CW-1:0]    lc_ram_wdata;
    logic [CW-1:0]    lc_rdata;

    // output register
    logic m_valid_reg;
    logic m_pred_reg;
    logic m_train_reg;

    gtbp_cfg #(
        .MAX_GLOBAL_BITS   (MAX_GLOBAL_BITS),
        .MAX_LOCAL_BITS    (MAX_LOCAL_BITS),
        .MAX_PC_INDEX_BITS (MAX_PC_INDEX_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign gmask     = cfg.gmask[GW-1:0];
    assign lmask     = cfg.lmask[LW-1:0];
    assign pmask     = cfg.pmask[PW-1:0];
    assign is_gshare = (cfg.mode == gtbp_pkg::MODE_GSHARE);
    assign is_tourn  = (cfg.mode == gtbp_pkg::MODE_TOURN);

    // ------------------------------------------------------------------
    // handshake: whole pipeline moves in lockstep
    // ------------------------------------------------------------------
    assign advance    = !m_valid_reg || m_tready;
    assign s_tready   = advance && !clr_busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign in_pc      = s_tdata[gtbp_pkg::PC_W-1:0];
    assign in_outcome = s_tdata[gtbp_pkg::PC_W];
    assign in_kind    = s_tuser;

    // ------------------------------------------------------------------
    // reset sweep over all tables
    // ------------------------------------------------------------------
    assign clr_cnt_next = clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (clr_cnt_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // global history and read addresses, taken at accept
    // ------------------------------------------------------------------
    assign gh_cur   = gh_reg & gmask;
    assign in_gsidx = (in_pc[GW-1:0] ^ gh_cur) & gmask;
    assign in_pidx  = in_pc[PW-1:0] & pmask;

    always_comb
    begin
        gh_next = gh_reg;
        if (accept && in_kind && (is_gshare || is_tourn))
        begin
            gh_next = {gh_cur[GW-2:0], in_outcome} & gmask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gh_reg <= '0;
        end
        else
        begin
            gh_reg <= gh_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg    <= in_kind;
            s1_outcome_reg <= in_outcome;
            s1_gh_reg      <= gh_cur;
            s1_gsidx_reg   <= in_gsidx;
            s1_pidx_reg    <= in_pidx;
        end
    end

    // forward the write going out now, then the one from the last advance
    always_comb
    begin
        priority if (lh_we_w && s2_pidx_reg == s1_pidx_reg)
            lh_res = lh_wdata_w;
        else if (lw_lh_valid_reg && lw_lh_addr_reg == s1_pidx_reg)
            lh_res = lw_lh_data_reg;
        else
            lh_res = lh_rdata;

        priority if (gsh_we_w && s2_gsidx_reg == s1_gsidx_reg)
            gsh_res = s2_outcome_reg;
        else if (lw_gsh_valid_reg && lw_gsh_addr_reg == s1_gsidx_reg)
            gsh_res = lw_gsh_data_reg;
        else
            gsh_res = gsh_rdata;

        priority if (gcc_we_w && s2_gh_reg == s1_gh_reg)
            gcc_res = gcc_wdata_w;
        else if (lw_gcc_valid_reg && lw_gcc_addr_reg == s1_gh_reg)
            gcc_res = lw_gcc_data_reg;
        else
            gcc_res = gcc_rdata;
    end

    assign s1_lidx = lh_res & lmask;

    // ------------------------------------------------------------------
    // stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_kind_reg    <= s1_kind_reg;
            s2_outcome_reg <= s1_outcome_reg;
            s2_gh_reg      <= s1_gh_reg;
            s2_gsidx_reg   <= s1_gsidx_reg;
            s2_pidx_reg    <= s1_pidx_reg;
            s2_lidx_reg    <= s1_lidx;
            s2_gsh_reg     <= gsh_res;
            s2_ch_reg      <= gcc_res[GCC_W-1:CW];
            s2_gc_reg      <= gcc_res[CW-1:0];
        end
    end

    // local counter was read at the last advance; pick up that edge's write
    always_comb
    begin
        priority if (lw_lc_valid_reg && lw_lc_addr_reg == s2_lidx_reg)
            lc_cur = lw_lc_data_reg;
        else
            lc_cur = lc_rdata;
    end

    assign use_global = s2_ch_reg[1];
    assign w_train    = s2_valid_reg && s2_kind_reg;

    always_comb
    begin
        if (use_global)
        begin
            guess_right = (s2_gc_reg[1] == s2_outcome_reg);
            ch_new      = guess_right ? gtbp_pkg::CTR_MAX : s2_ch_reg - 2'd1;
            gc_new      = gtbp_pkg::bump(s2_gc_reg, s2_outcome_reg);
            lc_new      = lc_cur;
        end
        else
        begin
            guess_right = (lc_cur[1] == s2_outcome_reg);
            ch_new      = guess_right ? gtbp_pkg::CTR_MIN : s2_ch_reg + 2'd1;
            gc_new      = s2_gc_reg;
            lc_new      = gtbp_pkg::bump(lc_cur, s2_outcome_reg);
        end
    end

    always_comb
    begin
        unique case (cfg.mode)
            gtbp_pkg::MODE_STATIC: pred_w = 1'b1;
            gtbp_pkg::MODE_GSHARE: pred_w = s2_gsh_reg;
            gtbp_pkg::MODE_TOURN:  pred_w = use_global ? s2_gc_reg[1] : lc_cur[1];
            default:               pred_w = 1'b0;
        endcase
    end

    assign gsh_we_w    = w_train && is_gshare;
    assign gcc_we_w    = w_train && is_tourn;
    assign lh_we_w     = gcc_we_w;
    assign lc_we_w     = gcc_we_w && !use_global;
    assign gcc_wdata_w = {ch_new, gc_new};
    assign lh_wdata_w  = {s2_lidx_reg[LW-2:0], s2_outcome_reg} & lmask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_gsh_valid_reg <= 1'b0;
            lw_gcc_valid_reg <= 1'b0;
            lw_lh_valid_reg  <= 1'b0;
            lw_lc_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            lw_gsh_valid_reg <= gsh_we_w;
            lw_gcc_valid_reg <= gcc_we_w;
            lw_lh_valid_reg  <= lh_we_w;
            lw_lc_valid_reg  <= lc_we_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lw_gsh_addr_reg <= s2_gsidx_reg;
            lw_gsh_data_reg <= s2_outcome_reg;
            lw_gcc_addr_reg <= s2_gh_reg;
            lw_gcc_data_reg <= gcc_wdata_w;
            lw_lh_addr_reg  <= s2_pidx_reg;
            lw_lh_data_reg  <= lh_wdata_w;
            lw_lc_addr_reg  <= s2_lidx_reg;
            lw_lc_data_reg  <= lc_new;
        end
    end

    // ------------------------------------------------------------------
    // tables: the sweep owns the write ports until it is done
    // ------------------------------------------------------------------
    assign gsh_ram_we    = clr_busy_reg || (gsh_we_w && advance);
    assign gsh_ram_waddr = clr_busy_reg ? clr_cnt_reg[GW-1:0] : s2_gsidx_reg;
    assign gsh_ram_wdata = clr_busy_reg ? 1'b0 : s2_outcome_reg;

    assign gcc_ram_we    = clr_busy_reg || (gcc_we_w && advance);
    assign gcc_ram_waddr = clr_busy_reg ? clr_cnt_reg[GW-1:0] : s2_gh_reg;
    assign gcc_ram_wdata = clr_busy_reg ? GCC_RST : gcc_wdata_w;

    assign lh_ram_we     = clr_busy_reg || (lh_we_w && advance);
    assign lh_ram_waddr  = clr_busy_reg ? clr_cnt_reg[PW-1:0] : s2_pidx_reg;
    assign lh_ram_wdata  = clr_busy_reg ? '0 : lh_wdata_w;

    assign lc_ram_we     = clr_busy_reg || (lc_we_w && advance);
    assign lc_ram_waddr  = clr_busy_reg ? clr_cnt_reg[LW-1:0] : s2_lidx_reg;
    assign lc_ram_wdata  = clr_busy_reg ? gtbp_pkg::CTR_WEAK_TAKEN : lc_new;

    gtbp_ram #(
        .WIDTH (1),
        .DEPTH (1 << GW)
    ) u_gsh_ram (
        .clk   (clk),
        .we    (gsh_ram_we),
        .waddr (gsh_ram_waddr),
        .wdata (gsh_ram_wdata),
        .re    (advance),
        .raddr (in_gsidx),
        .rdata (gsh_rdata)
    );

    // chooser in the upper half, global counter in the lower half
    gtbp_ram #(
        .WIDTH (GCC_W),
        .DEPTH (1 << GW)
    ) u_gcc_ram (
        .clk   (clk),
        .we    (gcc_ram_we),
        .waddr (gcc_ram_waddr),
        .wdata (gcc_ram_wdata),
        .re    (advance),
        .raddr (gh_cur),
        .rdata (gcc_rdata)
    );

    gtbp_ram #(
        .WIDTH (LW),
        .DEPTH (1 << PW)
    ) u_lh_ram (
        .clk   (clk),
        .we    (lh_ram_we),
        .waddr (lh_ram_waddr),
        .wdata (lh_ram_wdata),
        .re    (advance),
        .raddr (in_pidx),
        .rdata (lh_rdata)
    );

    gtbp_ram #(
        .WIDTH (CW),
        .DEPTH (1 << LW)
    ) u_lc_ram (
        .clk   (clk),
        .we    (lc_ram_we),
        .waddr (lc_ram_waddr),
        .wdata (lc_ram_wdata),
        .re    (advance),
        .raddr (s1_lidx),
        .rdata (lc_rdata)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_pred_reg  <= pred_w && !s2_kind_reg;
            m_train_reg <= s2_kind_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = gtbp_pkg::M_TDATA_W'(m_pred_reg);
    assign m_tuser  = m_train_reg;

`ifndef SYNTHESIS
    a_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (!s1_valid_reg && !s2_valid_reg && !m_valid_reg))
        else $error("item in pipeline during table sweep");

    a_train_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[0])
        else $error("train beat reports taken");

    a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> (clr_cnt_reg == '0))
        else $error("table sweep ended early");

    a_local_pair: assert property (@(posedge clk) disable iff (!rst_n)
        lc_we_w |-> (lh_we_w && is_tourn))
        else $error("local counter update without local history update");
`endif

endmodule

@@ design/gtbp_ram.sv @@
// ----------------------------------------------------------------------------
// gtbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the contents from before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/gtbp_cfg.sv @@
// ----------------------------------------------------------------------------
// gtbp_cfg
// Register file behind the APB port; hands out mode and clamped index masks.
// ----------------------------------------------------------------------------
module gtbp_cfg #(
    parameter int MAX_GLOBAL_BITS   = gtbp_pkg::MAX_GLOBAL_BITS_DEF,
    parameter int MAX_LOCAL_BITS    = gtbp_pkg::MAX_LOCAL_BITS_DEF,
    parameter int MAX_PC_INDEX_BITS = gtbp_pkg::MAX_PC_INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtbp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gtbp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gtbp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output gtbp_pkg::cfg_t                  cfg
);

    logic [gtbp_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic [gtbp_pkg::CFG_FIELD_W-1:0] ghb_reg, ghb_next;
    logic [gtbp_pkg::CFG_FIELD_W-1:0] lhb_reg, lhb_next;
    logic [gtbp_pkg::CFG_FIELD_W-1:0] pib_reg, pib_next;
    logic                             wr_en;
    logic [1:0]                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        mode_next = mode_reg;
        ghb_next  = ghb_reg;
        lhb_next  = lhb_reg;
        pib_next  = pib_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                gtbp_pkg::REG_MODE: mode_next = pwdata[gtbp_pkg::MODE_W-1:0];
                gtbp_pkg::REG_GHB:  ghb_next  = pwdata[gtbp_pkg::CFG_FIELD_W-1:0];
                gtbp_pkg::REG_LHB:  lhb_next  = pwdata[gtbp_pkg::CFG_FIELD_W-1:0];
                gtbp_pkg::REG_PIB:  pib_next  = pwdata[gtbp_pkg::CFG_FIELD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= gtbp_pkg::MODE_RST;
            ghb_reg  <= gtbp_pkg::GHB_RST;
            lhb_reg  <= gtbp_pkg::LHB_RST;
            pib_reg  <= gtbp_pkg::PIB_RST;
        end
        else
        begin
            mode_reg <= mode_next;
            ghb_reg  <= ghb_next;
            lhb_reg  <= lhb_next;
            pib_reg  <= pib_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gtbp_pkg::REG_MODE: prdata = gtbp_pkg::CFG_DATA_W'(mode_reg);
            gtbp_pkg::REG_GHB:  prdata = gtbp_pkg::CFG_DATA_W'(ghb_reg);
            gtbp_pkg::REG_LHB:  prdata = gtbp_pkg::CFG_DATA_W'(lhb_reg);
            gtbp_pkg::REG_PIB:  prdata = gtbp_pkg::CFG_DATA_W'(pib_reg);
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.gmask = gtbp_pkg::eff_mask(ghb_reg, MAX_GLOBAL_BITS);
    assign cfg.lmask = gtbp_pkg::eff_mask(lhb_reg, MAX_LOCAL_BITS);
    assign cfg.pmask = gtbp_pkg::eff_mask(pib_reg, MAX_PC_INDEX_BITS);

endmodule
